### design/lrs_pkg.sv
// Package for the lazy report scheduler: payload structs, configuration
// view, register indexes, result codes and timeout constants.
// No dependencies.
package lrs_pkg;

  // Result codes, same encoding as the partner's completion codes.
  localparam logic [2:0] CODE_OK          = 3'd0;
  localparam logic [2:0] CODE_NOT_RUNNING = 3'd1;
  localparam logic [2:0] CODE_TRANSPORT   = 3'd2;

  // Stall timeout shaping, in milliseconds.
  localparam int unsigned TimeoutW  = 16;
  localparam int unsigned SumW      = 26;
  localparam logic [SumW-1:0] GraceMs = SumW'(5000);
  localparam logic [SumW-1:0] FloorMs = SumW'(10000);
  localparam logic [SumW-1:0] CeilMs  = SumW'(60000);

  // Register index codes on the configuration port.
  typedef enum logic [2:0] {
    REG_SEND_ENABLE   = 3'd0,
    REG_HEARTBEAT     = 3'd1,
    REG_MIN_ATTEMPT   = 3'd2,
    REG_MAX_RETRIES   = 3'd3,
    REG_ATTEMPT_TMO   = 3'd4,
    REG_RETRY_DELAY   = 3'd5
  } reg_idx_e;

  // One poll tick.
  typedef struct packed {
    logic [31:0] now_ms;
    logic        completion_valid;
    logic [2:0]  completion_code;
    logic        link_running;
    logic [7:0]  current_level;
    logic [2:0]  accept_code;
    logic        force_immediate;
  } item_t;

  // One result per tick.
  typedef struct packed {
    logic        send_request;
    logic        restart_request;
    logic [2:0]  last_result_code;
    logic [31:0] last_success_ms;
    logic        awaiting_completion;
  } result_t;

  // Configuration as seen by the decision logic.
  typedef struct packed {
    logic                send_enable;
    logic [31:0]         heartbeat_interval_ms;
    logic [31:0]         min_attempt_interval_ms;
    logic [TimeoutW-1:0] stall_timeout_ms;
  } cfg_t;

endpackage

### design/lrs_cfg.sv
// Configuration registers of the lazy report scheduler, with the stall
// timeout worked out from them and held in a register. Depends on lrs_pkg.
module lrs_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output lrs_pkg::cfg_t      cfg_o
);
  import lrs_pkg::*;

  logic                send_enable_q;
  logic [31:0]         heartbeat_q;
  logic [31:0]         min_attempt_q;
  logic [7:0]          max_retries_q;
  logic [15:0]         attempt_tmo_q;
  logic [15:0]         retry_delay_q;
  logic [TimeoutW-1:0] timeout_q, timeout_d;
  logic [23:0]         tmo_prod, dly_prod;
  logic [SumW-1:0]     raw_sum;

  assign cfg_ready_o = 1'b1;

  // Register writes; an index beyond the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      send_enable_q <= 1'b1;
      heartbeat_q   <= 32'd60000;
      min_attempt_q <= 32'd1000;
      max_retries_q <= 8'd2;
      attempt_tmo_q <= 16'd5000;
      retry_delay_q <= 16'd1000;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SEND_ENABLE: send_enable_q <= cfg_data_i[0];
        REG_HEARTBEAT:   heartbeat_q   <= cfg_data_i;
        REG_MIN_ATTEMPT: min_attempt_q <= cfg_data_i;
        REG_MAX_RETRIES: max_retries_q <= cfg_data_i[7:0];
        REG_ATTEMPT_TMO: attempt_tmo_q <= cfg_data_i[15:0];
        REG_RETRY_DELAY: retry_delay_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Stall timeout: (r+1)*t + r*d + grace, clamped to the floor and ceiling.
  always_comb begin
    tmo_prod = 24'(max_retries_q) * 24'(attempt_tmo_q);
    dly_prod = 24'(max_retries_q) * 24'(retry_delay_q);
    raw_sum  = SumW'(tmo_prod) + SumW'(dly_prod) + SumW'(attempt_tmo_q) + GraceMs;
    if (raw_sum < FloorMs) begin
      timeout_d = FloorMs[TimeoutW-1:0];
    end else if (raw_sum > CeilMs) begin
      timeout_d = CeilMs[TimeoutW-1:0];
    end else begin
      timeout_d = raw_sum[TimeoutW-1:0];
    end
  end

  // The reset value follows from the reset register values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutW'(22000);
    end else begin
      timeout_q <= timeout_d;
    end
  end

  assign cfg_o = '{send_enable:             send_enable_q,
                   heartbeat_interval_ms:   heartbeat_q,
                   min_attempt_interval_ms: min_attempt_q,
                   stall_timeout_ms:        timeout_q};

endmodule

### design/lrs_core.sv
// Decision logic and scheduler state of the lazy report scheduler: takes
// one registered tick and forms its result. Depends on lrs_pkg.
module lrs_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  lrs_pkg::item_t   item_i,
  input  lrs_pkg::cfg_t    cfg_i,
  output lrs_pkg::result_t result_o
);
  import lrs_pkg::*;

  logic        await_q, await_d;
  logic        lazy_q, lazy_d;
  logic [31:0] attempt_q, attempt_d;
  logic [31:0] success_q, success_d;
  logic [7:0]  reported_q, reported_d;
  logic [7:0]  pending_q, pending_d;
  logic [2:0]  code_q, code_d;
  logic [31:0] since_attempt, since_success;
  logic        stall, due, send, restart;

  // Completion, stall check and send decision for one tick.
  always_comb begin
    await_d    = await_q;
    lazy_d     = lazy_q & ~item_i.force_immediate;
    attempt_d  = attempt_q;
    success_d  = success_q;
    reported_d = reported_q;
    pending_d  = pending_q;
    code_d     = code_q;
    send       = 1'b0;
    restart    = 1'b0;
    due        = 1'b0;

    if (item_i.completion_valid) begin
      code_d = item_i.completion_code;
      if (await_q) begin
        await_d = 1'b0;
        if (item_i.completion_code == CODE_OK) begin
          reported_d = pending_q;
          lazy_d     = 1'b1;
          success_d  = item_i.now_ms;
        end
      end
    end

    since_attempt = item_i.now_ms - attempt_q;
    since_success = item_i.now_ms - success_d;
    stall = await_d && (since_attempt > 32'(cfg_i.stall_timeout_ms));

    if (stall) begin
      await_d   = 1'b0;
      lazy_d    = 1'b0;
      code_d    = CODE_TRANSPORT;
      attempt_d = item_i.now_ms;
      restart   = 1'b1;
    end else if (cfg_i.send_enable && item_i.link_running && !await_d &&
                 since_attempt >= cfg_i.min_attempt_interval_ms) begin
      due = !lazy_d || (item_i.current_level != reported_d) ||
            (since_success >= cfg_i.heartbeat_interval_ms);
      if (due) begin
        send = 1'b1;
        if (item_i.accept_code == CODE_OK) begin
          await_d   = 1'b1;
          pending_d = item_i.current_level;
        end else begin
          code_d = item_i.accept_code;
        end
        attempt_d = item_i.now_ms;
      end
    end
  end

  // State advances only when the tick moves to the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      await_q    <= 1'b0;
      lazy_q     <= 1'b0;
      attempt_q  <= '0;
      success_q  <= '0;
      reported_q <= '0;
      pending_q  <= '0;
      code_q     <= CODE_NOT_RUNNING;
    end else if (fire_i) begin
      await_q    <= await_d;
      lazy_q     <= lazy_d;
      attempt_q  <= attempt_d;
      success_q  <= success_d;
      reported_q <= reported_d;
      pending_q  <= pending_d;
      code_q     <= code_d;
    end
  end

  assign result_o = '{send_request:        send,
                      restart_request:     restart,
                      last_result_code:    code_d,
                      last_success_ms:     success_d,
                      awaiting_completion: await_d};

endmodule

### design/lazy_report_scheduler_top.sv
// Top level of the lazy report scheduler: input register, decision core,
// result register and configuration block. Depends on lrs_pkg, lrs_cfg, lrs_core.

// Each poll tick gives exactly one result: the tick is held in the input
// register, then the decision logic loads the result register. A tick can
// be transferred every cycle while results are taken; the single result
// register limits buffering to one tick in flight per side when the output
// stalls. Configuration writes are taken every cycle; the stall timeout
// derived from them is held in its own register after the written ones.
// There is no clearing pass after reset.
module lazy_report_scheduler_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lrs_pkg::item_t    in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lrs_pkg::result_t  out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i
);
  import lrs_pkg::*;

  logic    in_valid_q;
  item_t   in_q;
  logic    out_valid_q;
  result_t out_q;
  result_t core_res;
  cfg_t    cfg;
  logic    out_free, fire;

  lrs_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  lrs_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .item_i  (in_q),
    .cfg_i   (cfg),
    .result_o(core_res)
  );

  // Pipeline handshake between the two register stages.
  assign out_free   = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= core_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A stall tick never offers a send.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.send_request && out_data_o.restart_request))
    else $error("send and restart requested on the same tick");

  // A stall tick leaves no send outstanding and reports a transport error.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.restart_request) |->
      (!out_data_o.awaiting_completion && out_data_o.last_result_code == CODE_TRANSPORT))
    else $error("restart without transport error or with a send outstanding");

  // A tick that moves on is in the result register on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("tick lost between input and result registers");

endmodule

### dv/tb_top.sv
// Self-checking testbench for the lazy report scheduler top level.
// Drives poll ticks and register writes, predicts every result in a scoreboard
// class and compares it field by field. Depends on lrs_pkg and the design files.
`timescale 1ns / 1ps

module tb_top;

  // Cycles without any transfer before the run is declared hung.
  localparam int unsigned HangLimit = 2000;
  // Cycles the receiver holds off in the back-pressure phase.
  localparam int unsigned LongHold = 40;
  // Register indexes that map to no register.
  localparam logic [2:0] REG_UNUSED_LO = 3'd6;
  localparam logic [2:0] REG_UNUSED_HI = 3'd7;

  // Scoreboard: keeps its own copy of the scheduler state, predicts one
  // result per accepted tick and checks results in order.
  class sched_scoreboard;
    bit          send_en;
    logic [31:0] heartbeat;
    logic [31:0] min_gap;
    logic [7:0]  retries;
    logic [15:0] attempt_tmo;
    logic [15:0] retry_delay;
    logic [31:0] stall_limit;

    bit          awaiting;
    bit          lazy;
    logic [31:0] attempt_ms;
    logic [31:0] success_ms;
    logic [7:0]  reported;
    logic [7:0]  pending;
    logic [2:0]  code;

    lrs_pkg::result_t expected_q[$];
    int unsigned mismatches;

    function new();
      send_en     = 1'b1;
      heartbeat   = 32'd60000;
      min_gap     = 32'd1000;
      retries     = 8'd2;
      attempt_tmo = 16'd5000;
      retry_delay = 16'd1000;
      awaiting    = 1'b0;
      lazy        = 1'b0;
      attempt_ms  = '0;
      success_ms  = '0;
      reported    = '0;
      pending     = '0;
      code        = lrs_pkg::CODE_NOT_RUNNING;
      mismatches  = 0;
      refresh_timeout();
    endfunction

    // Stall timeout from the partner's retry settings, clamped to its window.
    function void refresh_timeout();
      longint unsigned sum;
      sum = (longint'(retries) + 1) * longint'(attempt_tmo)
          + longint'(retries) * longint'(retry_delay) + longint'(lrs_pkg::GraceMs);
      if (sum < longint'(lrs_pkg::FloorMs)) sum = longint'(lrs_pkg::FloorMs);
      if (sum > longint'(lrs_pkg::CeilMs)) sum = longint'(lrs_pkg::CeilMs);
      stall_limit = 32'(sum);
    endfunction

    // A register write; indexes without a register are ignored.
    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        lrs_pkg::REG_SEND_ENABLE: send_en = data[0];
        lrs_pkg::REG_HEARTBEAT:   heartbeat = data;
        lrs_pkg::REG_MIN_ATTEMPT: min_gap = data;
        lrs_pkg::REG_MAX_RETRIES: retries = data[7:0];
        lrs_pkg::REG_ATTEMPT_TMO: attempt_tmo = data[15:0];
        lrs_pkg::REG_RETRY_DELAY: retry_delay = data[15:0];
        default: ;
      endcase
      refresh_timeout();
    endfunction

    // One accepted tick: update the state and queue the result it gives.
    function void note_tick(lrs_pkg::item_t t);
      lrs_pkg::result_t r;
      logic [31:0] since_attempt;
      logic [31:0] since_success;
      bit send;
      bit restart;
      bit due;
      send    = 1'b0;
      restart = 1'b0;
      if (t.force_immediate) lazy = 1'b0;

      // Completion from the partner.
      if (t.completion_valid) begin
        code = t.completion_code;
        if (awaiting) begin
          awaiting = 1'b0;
          if (t.completion_code == lrs_pkg::CODE_OK) begin
            reported   = pending;
            lazy       = 1'b1;
            success_ms = t.now_ms;
          end
        end
      end

      // Stall check first, otherwise a possible send.
      since_attempt = t.now_ms - attempt_ms;
      since_success = t.now_ms - success_ms;
      if (awaiting && since_attempt > stall_limit) begin
        awaiting   = 1'b0;
        lazy       = 1'b0;
        code       = lrs_pkg::CODE_TRANSPORT;
        attempt_ms = t.now_ms;
        restart    = 1'b1;
      end else if (send_en && t.link_running && !awaiting && since_attempt >= min_gap) begin
        due = !lazy || t.current_level != reported || since_success >= heartbeat;
        if (due) begin
          send = 1'b1;
          if (t.accept_code == lrs_pkg::CODE_OK) begin
            awaiting = 1'b1;
            pending  = t.current_level;
          end else begin
            code = t.accept_code;
          end
          attempt_ms = t.now_ms;
        end
      end

      r.send_request        = send;
      r.restart_request     = restart;
      r.last_result_code    = code;
      r.last_success_ms     = success_ms;
      r.awaiting_completion = awaiting;
      expected_q.push_back(r);
    endfunction

    function void report(string what, lrs_pkg::result_t exp, lrs_pkg::result_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: %s exp send=%0b restart=%0b code=%0d success=%h await=%0b",
                 $time, what, exp.send_request, exp.restart_request,
                 exp.last_result_code, exp.last_success_ms, exp.awaiting_completion);
        $display("%0t: %s got send=%0b restart=%0b code=%0d success=%h await=%0b",
                 $time, what, got.send_request, got.restart_request,
                 got.last_result_code, got.last_success_ms, got.awaiting_completion);
      end
    endfunction

    // One result transfer, compared with the oldest prediction.
    function void check_result(lrs_pkg::result_t got);
      lrs_pkg::result_t exp;
      bit bad;
      if (expected_q.size() == 0) begin
        exp = '0;
        report("unexpected result", exp, got);
      end else begin
        exp = expected_q.pop_front();
        bad = (got.send_request !== exp.send_request)
           || (got.restart_request !== exp.restart_request)
           || (got.last_result_code !== exp.last_result_code)
           || (got.last_success_ms !== exp.last_success_ms)
           || (got.awaiting_completion !== exp.awaiting_completion);
        if (bad) report("result mismatch", exp, got);
      end
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction

    function bit is_awaiting();
      return awaiting;
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  lrs_pkg::item_t   in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  lrs_pkg::result_t out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [2:0]       cfg_index = '0;
  logic [31:0]      cfg_data = '0;

  sched_scoreboard  sb;
  int unsigned      tx_idle_pct = 0;
  int unsigned      rx_stall_pct = 0;
  bit               hold_req = 1'b0;
  int unsigned      hold_left = 0;
  int unsigned      quiet_cycles = 0;
  logic [31:0]      clock_ms = '0;
  logic [7:0]       level_q = '0;

  lazy_report_scheduler_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #1 clk_i = ~clk_i;

  // Receiver: random stalls, or one long hold-off when requested.
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = LongHold;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) sb.check_result(out_data);
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= HangLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic lrs_pkg::item_t mk_tick(logic [31:0] now, bit cv, logic [2:0] cc,
                                             bit run, logic [7:0] lvl, logic [2:0] ac,
                                             bit force_now);
    lrs_pkg::item_t t;
    t.now_ms           = now;
    t.completion_valid = cv;
    t.completion_code  = cc;
    t.link_running     = run;
    t.current_level    = lvl;
    t.accept_code      = ac;
    t.force_immediate  = force_now;
    return t;
  endfunction

  // Next random tick. Most ticks move time forward plausibly and answer an
  // outstanding send; the rest are random noise.
  function automatic lrs_pkg::item_t next_tick();
    lrs_pkg::item_t t;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 15) begin
      t.now_ms           = $urandom;
      t.completion_valid = 1'($urandom_range(1));
      t.completion_code  = 3'($urandom_range(7));
      t.link_running     = 1'($urandom_range(1));
      t.current_level    = 8'($urandom_range(255));
      t.accept_code      = 3'($urandom_range(7));
      t.force_immediate  = 1'($urandom_range(1));
      clock_ms = t.now_ms;
      return t;
    end
    pick = $urandom_range(99);
    if (pick < 55) clock_ms = clock_ms + $urandom_range(1500);
    else if (pick < 85) clock_ms = clock_ms + $urandom_range(70000, 1500);
    else if (pick < 95) clock_ms = $urandom;
    else clock_ms = 32'hFFFF_FFFF - $urandom_range(3000);
    if ($urandom_range(99) < 30) level_q = 8'($urandom_range(255));
    t.now_ms = clock_ms;
    if (sb.is_awaiting()) begin
      t.completion_valid = ($urandom_range(99) < 65);
      t.completion_code  = ($urandom_range(99) < 70) ? lrs_pkg::CODE_OK
                                                     : 3'($urandom_range(7, 1));
    end else begin
      t.completion_valid = ($urandom_range(99) < 10);
      t.completion_code  = 3'($urandom_range(7));
    end
    t.link_running    = ($urandom_range(99) < 90);
    t.current_level   = level_q;
    t.accept_code     = ($urandom_range(99) < 75) ? lrs_pkg::CODE_OK
                                                  : 3'($urandom_range(7, 1));
    t.force_immediate = ($urandom_range(99) < 10);
    return t;
  endfunction

  // Offer one tick after a random gap and wait for its transfer.
  task automatic drive_tick(lrs_pkg::item_t t);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    sb.note_tick(t);
  endtask

  // Stop offering and wait until every predicted result has arrived.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  // Write every register, plus the unused indexes, which must be ignored.
  task automatic set_config(logic [31:0] en, logic [31:0] hb, logic [31:0] gap,
                            logic [31:0] rty, logic [31:0] tmo, logic [31:0] dly);
    cfg_write(lrs_pkg::REG_SEND_ENABLE, en);
    cfg_write(lrs_pkg::REG_HEARTBEAT, hb);
    cfg_write(lrs_pkg::REG_MIN_ATTEMPT, gap);
    cfg_write(lrs_pkg::REG_MAX_RETRIES, rty);
    cfg_write(lrs_pkg::REG_ATTEMPT_TMO, tmo);
    cfg_write(lrs_pkg::REG_RETRY_DELAY, dly);
    cfg_write(REG_UNUSED_LO, $urandom);
    cfg_write(REG_UNUSED_HI, $urandom);
    cfg_valid <= 1'b0;
    repeat (3) @(posedge clk_i);
  endtask

  task automatic run_phase(int unsigned count, int unsigned tx_pct, int unsigned rx_pct);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    repeat (count) drive_tick(next_tick());
    drain();
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed ticks at reset settings.
    // Too soon after the reset attempt time, so nothing is offered.
    drive_tick(mk_tick(32'd0, 1'b0, 3'd0, 1'b1, 8'h00, 3'd0, 1'b0));
    // First send, accepted, then confirmed: lazy mode starts.
    drive_tick(mk_tick(32'd1000, 1'b0, 3'd0, 1'b1, 8'hFF, 3'd0, 1'b0));
    drive_tick(mk_tick(32'd1500, 1'b1, lrs_pkg::CODE_OK, 1'b1, 8'hFF, 3'd0, 1'b0));
    // Lazy with an unchanged level: no report.
    drive_tick(mk_tick(32'd2600, 1'b0, 3'd0, 1'b1, 8'hFF, 3'd0, 1'b0));
    // Level change, but the partner refuses the send.
    drive_tick(mk_tick(32'd2700, 1'b0, 3'd0, 1'b1, 8'h00, 3'd5, 1'b0));
    // Completion while not awaiting only sets the result code.
    drive_tick(mk_tick(32'd3800, 1'b1, 3'd7, 1'b1, 8'h00, 3'd0, 1'b0));
    // Failed completion while awaiting.
    drive_tick(mk_tick(32'd4000, 1'b1, 3'd3, 1'b1, 8'h00, 3'd0, 1'b0));
    // New send, then a stall with no completion.
    drive_tick(mk_tick(32'd5000, 1'b0, 3'd0, 1'b1, 8'h00, 3'd0, 1'b0));
    drive_tick(mk_tick(32'd27001, 1'b0, 3'd0, 1'b1, 8'h00, 3'd0, 1'b0));
    // Link down, then up with force.
    drive_tick(mk_tick(32'd28001, 1'b0, 3'd0, 1'b0, 8'h10, 3'd0, 1'b1));
    drive_tick(mk_tick(32'd28001, 1'b0, 3'd0, 1'b1, 8'h10, 3'd0, 1'b1));
    // Force and an ok completion on the same tick.
    drive_tick(mk_tick(32'd28500, 1'b1, lrs_pkg::CODE_OK, 1'b1, 8'h10, 3'd0, 1'b1));
    // Heartbeat expiry across a large time step, then a wrap of the clock.
    drive_tick(mk_tick(32'hFFFF_FFFF, 1'b0, 3'd0, 1'b1, 8'h10, 3'd0, 1'b0));
    drive_tick(mk_tick(32'h0000_0100, 1'b1, lrs_pkg::CODE_OK, 1'b1, 8'h10, 3'd0, 1'b0));
    drive_tick(mk_tick(32'h0000_0200, 1'b1, lrs_pkg::CODE_NOT_RUNNING, 1'b1, 8'h10, 3'd0,
                       1'b0));
    // All fields at their extremes.
    drive_tick(mk_tick(32'hFFFF_FFFF, 1'b1, 3'd7, 1'b1, 8'hFF, 3'd7, 1'b1));
    drive_tick(mk_tick(32'd0, 1'b0, 3'd0, 1'b0, 8'h00, 3'd0, 1'b0));
    drive_tick(mk_tick(32'h8000_0000, 1'b0, 3'd0, 1'b1, 8'h80, 3'd0, 1'b0));
    drain();
    clock_ms = 32'h8000_0000;

    // Random phases, each under its own settings and idling pattern.
    set_config(32'd1, 32'd60000, 32'd1000, 32'd2, 32'd5000, 32'd1000);
    run_phase(92, 0, 0);
    set_config(32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    run_phase(92, 74, 0);
    set_config(32'd0, 32'd5000, 32'd100, 32'd1, 32'd2000, 32'd500);
    run_phase(92, 0, 74);
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd255, 32'd65535, 32'd65535);
    run_phase(92, 31, 31);
    // Long receiver hold-off while ticks keep coming, to fill the block.
    set_config(32'd1, 32'd20000, 32'd500, 32'd3, 32'd3000, 32'd2000);
    hold_req = 1'b1;
    run_phase(92, 0, 0);
    set_config($urandom, $urandom_range(100000), $urandom_range(3000), $urandom,
               $urandom, $urandom);
    run_phase(92, 74, 0);
    set_config(32'd1, 32'd3000, 32'd200, 32'd0, 32'd4000, 32'd0);
    run_phase(92, 0, 74);
    set_config(32'd1, $urandom_range(100000), $urandom_range(3000), $urandom_range(5),
               $urandom_range(8000), $urandom_range(3000));
    run_phase(92, 31, 31);

    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
